// ----- sv/ajb_pkg.sv -----
// Shared types, constants and helpers for the audio jitter buffer.
// No dependencies.
`default_nettype none
package ajb_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int HANDLE_BITS = 16;
   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] KIND_PUSH  = 2'd0;
   localparam logic [1:0] KIND_PULL  = 2'd1;
   localparam logic [1:0] KIND_RESET = 2'd2;

   localparam logic [1:0] ACT_NONE    = 2'd0;
   localparam logic [1:0] ACT_PLAY    = 2'd1;
   localparam logic [1:0] ACT_CONCEAL = 2'd2;
   localparam logic [1:0] ACT_SILENCE = 2'd3;

   localparam logic [1:0] CSR_PREBUFFER = 2'd0;
   localparam logic [1:0] CSR_PRIME     = 2'd1;
   localparam logic [1:0] CSR_SILENCE   = 2'd2;
   localparam logic [1:0] CSR_CONCEAL   = 2'd3;

   localparam logic [3:0]  PREBUFFER_RST = 4'd2;
   localparam logic [23:0] PRIME_RST     = 24'd60000;
   localparam logic [23:0] SILENCE_RST   = 24'd100000;
   localparam logic [2:0]  CONCEAL_RST   = 3'd2;

   // word travelling down the cell chain
   typedef struct packed {
      logic                   go;
      logic                   match_found;
      logic [63:0]            match_ts;
      logic [HANDLE_BITS-1:0] match_handle;
      logic                   free_found;
      logic [IDX_W-1:0]       free_idx;
      logic [IDX_W-1:0]       match_idx;
      logic                   low_found;
      logic [IDX_W-1:0]       low_idx;
      logic [31:0]            low_seq;
      logic                   later_found;
      logic [31:0]            later_seq;
      logic [CNT_W-1:0]       cnt;
   } scan_type;

   // broadcast update to all cells
   typedef struct packed {
      logic                   clear;
      logic                   wr_en;
      logic [IDX_W-1:0]       wr_idx;
      logic [31:0]            wr_seq;
      logic [63:0]            wr_ts;
      logic [HANDLE_BITS-1:0] wr_handle;
      logic                   kill_en;
      logic [IDX_W-1:0]       kill_idx;
      logic                   trim_en;
      logic [31:0]            trim_seq;
   } cmd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PUSH_CHK,
      S_PUSH_LAUNCH,
      S_PUSH_WAIT,
      S_PUSH_WRITE,
      S_PUSH_LAUNCH2,
      S_PUSH_WAIT2,
      S_PUSH_CURSOR,
      S_PULL_LAUNCH,
      S_PULL_WAIT,
      S_PULL_PRIME,
      S_PULL_LAUNCH2,
      S_PULL_WAIT2,
      S_PULL_DECIDE
   } state_type;

   // now >= base + delta, sum taken without wrap
   function automatic logic reached(input logic [63:0] now, input logic [63:0] base,
                                    input logic [23:0] delta);
      logic [64:0] sum;
      sum = {1'b0, base} + {41'd0, delta};
      return {1'b0, now} >= sum;
   endfunction

endpackage
`default_nettype wire

// ----- sv/audio_jitter_buffer_top.sv -----
// Top level of the audio jitter buffer: settings registers, slot cell chain, sequencer.
// Depends on ajb_pkg, ajb_cell, ajb_ctrl.
//
//   channel | direction | handshake              | word
//   req_    | in        | req_valid / req_ready  | kind, time, frame fields
//   rsp_    | out       | rsp_valid / rsp_ready  | action, played frame fields
//   csr_    | in        | csr_valid / csr_ready  | register index, data
//
// One word at a time. A search walks the eight-cell chain, registered in each cell.
// Push: ignored, one search, or a second search on overflow while primed.
// Pull: one search, and a second one when playback starts; one result per pull.
// Reset clears all slots at once. A waiting result does not block new words;
// only a pull that finishes while the result register is still full waits.
`default_nettype none
module audio_jitter_buffer_top import ajb_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [1:0]             req_kind,
   input  wire logic [63:0]            req_now_us,
   input  wire logic [31:0]            req_frame_sequence,
   input  wire logic [63:0]            req_frame_timestamp,
   input  wire logic                   req_payload_present,
   input  wire logic [HANDLE_BITS-1:0] req_payload_handle,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [1:0]                  rsp_action,
   output logic [31:0]                 rsp_out_sequence,
   output logic [63:0]                 rsp_out_timestamp,
   output logic [HANDLE_BITS-1:0]      rsp_out_handle,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [1:0]             csr_index,
   input  wire logic [23:0]            csr_data
);

   logic [3:0]  prebuffer_ff;
   logic [23:0] prime_ff;
   logic [23:0] silence_ff;
   logic [2:0]  conceal_ff;

   scan_type    link [QUEUE_DEPTH+1];
   logic [31:0] key;
   cmd_type     cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prebuffer_ff <= PREBUFFER_RST;
         prime_ff     <= PRIME_RST;
         silence_ff   <= SILENCE_RST;
         conceal_ff   <= CONCEAL_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PREBUFFER: prebuffer_ff <= csr_data[3:0];
            CSR_PRIME:     prime_ff     <= csr_data;
            CSR_SILENCE:   silence_ff   <= csr_data;
            CSR_CONCEAL:   conceal_ff   <= csr_data[2:0];
            default:       ;
         endcase
      end
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      ajb_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IDX_W'(i)),
         .key      (key),
         .cmd      (cmd),
         .scan_in  (link[i]),
         .scan_out (link[i+1])
      );
   end

   ajb_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_now_us          (req_now_us),
      .req_frame_sequence  (req_frame_sequence),
      .req_frame_timestamp (req_frame_timestamp),
      .req_payload_present (req_payload_present),
      .req_payload_handle  (req_payload_handle),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_action          (rsp_action),
      .rsp_out_sequence    (rsp_out_sequence),
      .rsp_out_timestamp   (rsp_out_timestamp),
      .rsp_out_handle      (rsp_out_handle),
      .cfg_prebuffer       (prebuffer_ff),
      .cfg_prime           (prime_ff),
      .cfg_silence         (silence_ff),
      .cfg_conceal         (conceal_ff),
      .scan_start          (link[0]),
      .scan_done           (link[QUEUE_DEPTH]),
      .key                 (key),
      .cmd                 (cmd)
   );

endmodule
`default_nettype wire

// ----- sv/ajb_cell.sv -----
// One frame slot of the buffer and one stage of the search chain.
// Depends on ajb_pkg.
`default_nettype none
module ajb_cell import ajb_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [IDX_W-1:0] cell_idx,
   input  wire logic [31:0]      key,
   input  wire cmd_type          cmd,
   input  wire scan_type         scan_in,
   output scan_type              scan_out
);

   logic                   valid_ff, valid_in;
   logic [31:0]            seq_ff;
   logic [63:0]            ts_ff;
   logic [HANDLE_BITS-1:0] handle_ff;
   scan_type               scan_ff, scan_in_next;

   logic wr_hit;

   assign wr_hit = cmd.wr_en && cmd.wr_idx == cell_idx;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear) begin
         valid_in = 1'b0;
      end else if (wr_hit) begin
         valid_in = 1'b1;
      end else if (cmd.kill_en && cmd.kill_idx == cell_idx) begin
         valid_in = 1'b0;
      end else if (cmd.trim_en && seq_ff < cmd.trim_seq) begin
         valid_in = 1'b0;
      end
   end

   always_comb begin
      scan_in_next = scan_in;
      if (valid_ff) begin
         scan_in_next.cnt = scan_in.cnt + CNT_W'(1);
         if (!scan_in.match_found && seq_ff == key) begin
            scan_in_next.match_found  = 1'b1;
            scan_in_next.match_idx    = cell_idx;
            scan_in_next.match_ts     = ts_ff;
            scan_in_next.match_handle = handle_ff;
         end
         if (!scan_in.low_found || seq_ff < scan_in.low_seq) begin
            scan_in_next.low_found = 1'b1;
            scan_in_next.low_idx   = cell_idx;
            scan_in_next.low_seq   = seq_ff;
         end
         if (seq_ff > key && (!scan_in.later_found || seq_ff < scan_in.later_seq)) begin
            scan_in_next.later_found = 1'b1;
            scan_in_next.later_seq   = seq_ff;
         end
      end else if (!scan_in.free_found) begin
         scan_in_next.free_found = 1'b1;
         scan_in_next.free_idx   = cell_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         scan_ff.go <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         scan_ff.go <= scan_in_next.go;
      end
      scan_ff.match_found  <= scan_in_next.match_found;
      scan_ff.match_ts     <= scan_in_next.match_ts;
      scan_ff.match_handle <= scan_in_next.match_handle;
      scan_ff.free_found   <= scan_in_next.free_found;
      scan_ff.free_idx     <= scan_in_next.free_idx;
      scan_ff.match_idx    <= scan_in_next.match_idx;
      scan_ff.low_found    <= scan_in_next.low_found;
      scan_ff.low_idx      <= scan_in_next.low_idx;
      scan_ff.low_seq      <= scan_in_next.low_seq;
      scan_ff.later_found  <= scan_in_next.later_found;
      scan_ff.later_seq    <= scan_in_next.later_seq;
      scan_ff.cnt          <= scan_in_next.cnt;
      if (wr_hit) begin
         seq_ff    <= cmd.wr_seq;
         ts_ff     <= cmd.wr_ts;
         handle_ff <= cmd.wr_handle;
      end
   end

   assign scan_out = scan_ff;

endmodule
`default_nettype wire

// ----- sv/ajb_ctrl.sv -----
// Sequencer for push, pull and reset; holds cursor, flags, times and result word.
// Depends on ajb_pkg; drives the cell chain of ajb_cell.
`default_nettype none
module ajb_ctrl import ajb_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [1:0]             req_kind,
   input  wire logic [63:0]            req_now_us,
   input  wire logic [31:0]            req_frame_sequence,
   input  wire logic [63:0]            req_frame_timestamp,
   input  wire logic                   req_payload_present,
   input  wire logic [HANDLE_BITS-1:0] req_payload_handle,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [1:0]                  rsp_action,
   output logic [31:0]                 rsp_out_sequence,
   output logic [63:0]                 rsp_out_timestamp,
   output logic [HANDLE_BITS-1:0]      rsp_out_handle,
   input  wire logic [3:0]             cfg_prebuffer,
   input  wire logic [23:0]            cfg_prime,
   input  wire logic [23:0]            cfg_silence,
   input  wire logic [2:0]             cfg_conceal,
   output scan_type                    scan_start,
   input  wire scan_type               scan_done,
   output logic [31:0]                 key,
   output cmd_type                     cmd
);

   state_type state_ff, state_in;

   logic [1:0]             kind_ff;
   logic [63:0]            now_ff;
   logic [31:0]            seq_ff;
   logic [63:0]            ts_ff;
   logic                   present_ff;
   logic [HANDLE_BITS-1:0] handle_ff;
   scan_type               res_ff;

   logic [31:0] exp_ff, exp_in;
   logic        primed_ff, primed_in;
   logic        played_ff, played_in;
   logic        arrival_ff, arrival_in;
   logic [63:0] first_ff, first_in;
   logic [63:0] last_ff, last_in;
   logic        waited_ff, quiet_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_action_ff;
   logic [31:0]            rsp_seq_ff;
   logic [63:0]            rsp_ts_ff;
   logic [HANDLE_BITS-1:0] rsp_handle_ff;

   logic                   emit;
   logic [1:0]             emit_action;
   logic                   launch;
   logic                   accept;
   logic                   rsp_busy;
   logic                   push_skip;
   logic                   dropped;
   logic [3:0]             need;
   logic                   enough;
   logic [31:0]            gap;

   assign accept    = req_valid && req_ready;
   assign rsp_busy  = rsp_valid_ff && !rsp_ready;
   assign push_skip = seq_ff == 32'd0 || !present_ff || (primed_ff && seq_ff < exp_ff);
   assign dropped   = !res_ff.match_found && !res_ff.free_found;
   assign need      = (cfg_prebuffer == 4'd0) ? 4'd1 : cfg_prebuffer;
   assign enough    = 32'(res_ff.cnt) >= 32'(need);
   assign gap       = res_ff.later_seq - exp_ff;
   assign key       = (kind_ff == KIND_PUSH) ? seq_ff : exp_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_kind == KIND_PUSH) state_in = S_PUSH_CHK;
               else if (req_kind == KIND_PULL) state_in = S_PULL_LAUNCH;
            end
         end
         S_PUSH_CHK:     state_in = push_skip ? S_IDLE : S_PUSH_LAUNCH;
         S_PUSH_LAUNCH:  state_in = S_PUSH_WAIT;
         S_PUSH_WAIT:    if (scan_done.go) state_in = S_PUSH_WRITE;
         S_PUSH_WRITE:   state_in = (dropped && primed_ff) ? S_PUSH_LAUNCH2 : S_IDLE;
         S_PUSH_LAUNCH2: state_in = S_PUSH_WAIT2;
         S_PUSH_WAIT2:   if (scan_done.go) state_in = S_PUSH_CURSOR;
         S_PUSH_CURSOR:  state_in = S_IDLE;
         S_PULL_LAUNCH:  state_in = S_PULL_WAIT;
         S_PULL_WAIT:    if (scan_done.go) state_in = S_PULL_PRIME;
         S_PULL_PRIME: begin
            if (!rsp_busy) begin
               if (primed_ff) state_in = S_PULL_DECIDE;
               else if (res_ff.cnt == '0 || (!enough && !waited_ff)) state_in = S_IDLE;
               else state_in = S_PULL_LAUNCH2;
            end
         end
         S_PULL_LAUNCH2: state_in = S_PULL_WAIT2;
         S_PULL_WAIT2:   if (scan_done.go) state_in = S_PULL_DECIDE;
         S_PULL_DECIDE:  if (!rsp_busy) state_in = S_IDLE;
         default:        state_in = S_IDLE;
      endcase
   end

   always_comb begin
      exp_in      = exp_ff;
      primed_in   = primed_ff;
      played_in   = played_ff;
      arrival_in  = arrival_ff;
      first_in    = first_ff;
      last_in     = last_ff;
      cmd         = '0;
      launch      = 1'b0;
      emit        = 1'b0;
      emit_action = ACT_NONE;
      req_ready   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_kind == KIND_RESET) begin
               cmd.clear  = 1'b1;
               exp_in     = '0;
               primed_in  = 1'b0;
               played_in  = 1'b0;
               arrival_in = 1'b0;
               first_in   = '0;
               last_in    = '0;
            end
         end
         S_PUSH_CHK: begin
            if (!push_skip) begin
               last_in    = now_ff;
               arrival_in = 1'b1;
               if (!arrival_ff) first_in = now_ff;
            end
         end
         S_PUSH_LAUNCH, S_PUSH_LAUNCH2, S_PULL_LAUNCH, S_PULL_LAUNCH2: launch = 1'b1;
         S_PUSH_WRITE: begin
            cmd.wr_seq    = seq_ff;
            cmd.wr_ts     = ts_ff;
            cmd.wr_handle = handle_ff;
            if (res_ff.match_found) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_idx = res_ff.match_idx;
            end else if (res_ff.free_found) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_idx = res_ff.free_idx;
            end else if (res_ff.low_found && seq_ff > res_ff.low_seq) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_idx = res_ff.low_idx;
            end
         end
         S_PUSH_CURSOR: begin
            if (res_ff.low_found && res_ff.low_seq > exp_ff) exp_in = res_ff.low_seq;
         end
         S_PULL_PRIME: begin
            if (!rsp_busy && !primed_ff) begin
               if (res_ff.cnt == '0 || (!enough && !waited_ff)) begin
                  emit = 1'b1;
               end else begin
                  primed_in = 1'b1;
                  exp_in    = res_ff.low_seq;
               end
            end
         end
         S_PULL_DECIDE: begin
            if (!rsp_busy) begin
               emit = 1'b1;
               if (res_ff.match_found) begin
                  emit_action  = ACT_PLAY;
                  cmd.kill_en  = 1'b1;
                  cmd.kill_idx = res_ff.match_idx;
                  played_in    = 1'b1;
                  exp_in       = exp_ff + 32'd1;
               end else if (!res_ff.later_found) begin
                  if (played_ff && arrival_ff && quiet_ff) begin
                     emit_action = ACT_SILENCE;
                     cmd.clear   = 1'b1;
                     exp_in      = '0;
                     primed_in   = 1'b0;
                     played_in   = 1'b0;
                     arrival_in  = 1'b0;
                     first_in    = '0;
                     last_in     = '0;
                  end
               end else if (gap <= 32'(cfg_conceal) && arrival_ff && !quiet_ff) begin
                  emit_action = ACT_CONCEAL;
                  exp_in      = exp_ff + 32'd1;
               end else begin
                  emit_action  = ACT_SILENCE;
                  cmd.trim_en  = 1'b1;
                  cmd.trim_seq = res_ff.later_seq;
                  primed_in    = 1'b0;
                  played_in    = 1'b0;
                  arrival_in   = 1'b1;
                  exp_in       = '0;
                  first_in     = now_ff;
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      scan_start    = '0;
      scan_start.go = launch;
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         exp_ff       <= '0;
         primed_ff    <= 1'b0;
         played_ff    <= 1'b0;
         arrival_ff   <= 1'b0;
         first_ff     <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         exp_ff       <= exp_in;
         primed_ff    <= primed_in;
         played_ff    <= played_in;
         arrival_ff   <= arrival_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         kind_ff    <= req_kind;
         now_ff     <= req_now_us;
         seq_ff     <= req_frame_sequence;
         ts_ff      <= req_frame_timestamp;
         present_ff <= req_payload_present;
         handle_ff  <= req_payload_handle;
      end
      if (scan_done.go) res_ff <= scan_done;
      waited_ff <= arrival_ff && reached(now_ff, first_ff, cfg_prime);
      quiet_ff  <= reached(now_ff, last_ff, cfg_silence);
      if (emit) begin
         rsp_action_ff <= emit_action;
         rsp_seq_ff    <= (emit_action == ACT_PLAY) ? exp_ff : 32'd0;
         rsp_ts_ff     <= (emit_action == ACT_PLAY) ? res_ff.match_ts : 64'd0;
         rsp_handle_ff <= (emit_action == ACT_PLAY) ? res_ff.match_handle : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_action        = rsp_action_ff;
   assign rsp_out_sequence  = rsp_seq_ff;
   assign rsp_out_timestamp = rsp_ts_ff;
   assign rsp_out_handle    = rsp_handle_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result word overwritten");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      scan_done.go |-> (state_ff == S_PUSH_WAIT || state_ff == S_PUSH_WAIT2 ||
                        state_ff == S_PULL_WAIT || state_ff == S_PULL_WAIT2))
      else $error("search word outside wait");

   a_played_primed: assert property (@(posedge clock) disable iff (reset)
      played_ff |-> primed_ff)
      else $error("played while not primed");

   a_key_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUSH_WAIT || state_ff == S_PULL_WAIT) && !scan_done.go
      |=> $stable(key))
      else $error("search key moved");

endmodule
`default_nettype wire
